### sv/btu_pkg.sv
// Shared types, constants and packing functions for the bus timing unit responder.
// No dependencies; btu_div and the top level import this package, btu_ram does not.
package btu_pkg;

    localparam int NUM_BUSES   = 3;
    localparam int NUM_READERS = 6;
    localparam int REPLY_WORDS = 7;
    localparam int FIRST_BUS   = 20;
    localparam int SYNC_BIT    = 24;

    localparam int BUS_W     = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
    localparam int READER_W  = $clog2(NUM_READERS);
    localparam int LEFT_W    = $clog2(REPLY_WORDS + 1);
    localparam int WIDX_W    = $clog2(REPLY_WORDS);
    localparam int RAM_DEPTH = NUM_BUSES * REPLY_WORDS;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int WORD_W    = 16;
    localparam int CMDW_W    = 24;
    localparam int DATA_W    = 25;
    localparam int MS_W      = 35;
    localparam int DIV_W     = 10;
    localparam int PADDR_W   = 3;

    localparam logic [DATA_W-1:0] SYNC_WORD = DATA_W'(64'd1 << SYNC_BIT);

    localparam logic [DIV_W-1:0] DIV_MS  = 10'd1000;
    localparam logic [DIV_W-1:0] DIV_SEC = 10'd60;
    localparam logic [DIV_W-1:0] DIV_MIN = 10'd60;
    localparam logic [DIV_W-1:0] DIV_HR  = 10'd24;

    // The divider takes the dividend in two 18-bit digits. Each partial dividend stays below
    // divisor * 2^18 < 2^28, so a reciprocal rounded up with a shift of 28 plus the divisor's
    // bit length gives the exact quotient digit.
    localparam int CHUNK_W    = 18;
    localparam int NUM_CHUNKS = 2;
    localparam int STEP_W     = $clog2(2 * NUM_CHUNKS);
    localparam int PART_W     = DIV_W + CHUNK_W;
    localparam int RCP_W      = 29;
    localparam int PROD_W     = PART_W + RCP_W;
    localparam int SH_MS      = PART_W + $clog2(int'(DIV_MS));
    localparam int SH_SEC     = PART_W + $clog2(int'(DIV_SEC));
    localparam int SH_HR      = PART_W + $clog2(int'(DIV_HR));

    localparam logic [RCP_W-1:0] RCP_MS  =
        RCP_W'(((64'd1 << SH_MS) + 64'(DIV_MS) - 64'd1) / 64'(DIV_MS));
    localparam logic [RCP_W-1:0] RCP_SEC =
        RCP_W'(((64'd1 << SH_SEC) + 64'(DIV_SEC) - 64'd1) / 64'(DIV_SEC));
    localparam logic [RCP_W-1:0] RCP_HR  =
        RCP_W'(((64'd1 << SH_HR) + 64'(DIV_HR) - 64'd1) / 64'(DIV_HR));

    localparam logic [4:0]  DEV_ADDR_RESET   = 5'd10;
    localparam logic [18:0] READ_FIELD_RESET = 19'h24C26;

    typedef enum logic [1:0] {
        CMD_TX_CMD  = 2'd0,
        CMD_TX_WORD = 2'd1,
        CMD_POLL    = 2'd2,
        CMD_RX_WORD = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_DEV_ADDR   = 1'b0,
        REG_READ_FIELD = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_MS  = 2'd0,
        PH_SEC = 2'd1,
        PH_MIN = 2'd2,
        PH_HR  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDATA,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PACK,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [MS_W-1:0]  dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MS_W-1:0]  quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    // Tens digit of a value below 100, by multiplying with 205/2048.
    function automatic logic [3:0] tens_of(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return 4'(p >> 11);
    endfunction

    function automatic logic [3:0] units_of(input logic [6:0] x, input logic [3:0] t);
        return 4'(x - 7'(t) * 7'd10);
    endfunction

    // Days (below 400) and hours packed as BCD; hundreds by 41/4096.
    function automatic logic [WORD_W-1:0] pack_dyhr(input logic [8:0] days,
                                                    input logic [4:0] hr);
        logic [14:0] p;
        logic [1:0]  hun;
        logic [6:0]  drem;
        logic [3:0]  dt;
        logic [3:0]  ht;
        p    = 15'(days) * 15'd41;
        hun  = 2'(p >> 12);
        drem = 7'(days - 9'(hun) * 9'd100);
        dt   = tens_of(drem);
        ht   = tens_of(7'(hr));
        return {hun, dt, units_of(drem, dt), ht[1:0], units_of(7'(hr), ht)};
    endfunction

    function automatic logic [WORD_W-1:0] pack_mnsc(input logic [5:0] min,
                                                    input logic [5:0] sec);
        logic [3:0] mt;
        logic [3:0] st;
        mt = tens_of(7'(min));
        st = tens_of(7'(sec));
        return {mt[2:0], units_of(7'(min), mt), st[2:0], units_of(7'(sec), st), 2'b00};
    endfunction

    function automatic logic [WORD_W-1:0] pack_msec(input logic [DIV_W-1:0] ms);
        return {3'b000, ms, 3'b000};
    endfunction

endpackage

### sv/btu_div.sv
// Divider by one of the time constants: two 18-bit digits, each a reciprocal multiply step
// followed by a subtract step. Depends on btu_pkg for widths, reciprocals and the structs.
module btu_div (
    input  logic              clk,
    input  logic              rst_n,
    input  btu_pkg::div_req_t req,
    output btu_pkg::div_rsp_t rsp
);
    import btu_pkg::*;

    logic [2*CHUNK_W-1:0] num_reg;
    logic [2*CHUNK_W-1:0] quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [PART_W-1:0]    part_reg;
    logic [CHUNK_W-1:0]   digit_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [PART_W-1:0]    part;
    logic [PROD_W-1:0]    prod;
    logic [CHUNK_W-1:0]   digit;
    logic [PART_W-1:0]    back;
    logic [DIV_W-1:0]     rem_next;

    // Minutes share the divisor of seconds, so one arm serves both.
    always_comb
    begin
        part = {rem_reg, num_reg[2*CHUNK_W-1 -: CHUNK_W]};
        case (dvs_reg)
            DIV_MS:
            begin
                prod  = PROD_W'(part) * PROD_W'(RCP_MS);
                digit = CHUNK_W'(prod >> SH_MS);
            end
            DIV_SEC:
            begin
                prod  = PROD_W'(part) * PROD_W'(RCP_SEC);
                digit = CHUNK_W'(prod >> SH_SEC);
            end
            default:
            begin
                prod  = PROD_W'(part) * PROD_W'(RCP_HR);
                digit = CHUNK_W'(prod >> SH_HR);
            end
        endcase
        back     = PART_W'(digit_reg) * PART_W'(dvs_reg);
        rem_next = DIV_W'(part_reg - back);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (run_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(2 * NUM_CHUNKS - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Even steps estimate a quotient digit, odd steps settle the remainder and shift on.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= (2 * CHUNK_W)'(req.dividend);
            quo_reg <= '0;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            if (!step_reg[0])
            begin
                part_reg  <= part;
                digit_reg <= digit;
            end
            else
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[CHUNK_W-1:0], digit_reg};
                num_reg <= {num_reg[CHUNK_W-1:0], CHUNK_W'(0)};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg[MS_W-1:0];
    assign rsp.remainder = rem_reg;

    a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !run_reg)
        else $error("divider started while a division was running");

    a_done_pulse : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && step_reg[0]) |-> (part_reg >= back) && (rem_next < dvs_reg))
        else $error("partial remainder not below the divisor");

endmodule

### sv/btu_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// Generic; no package dependency.
module btu_ram #(
    parameter int DEPTH = 21,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/bus_timing_unit_responder.sv
// Top level of the bus timing unit responder: decode, per-reader state, fill sequencer.
// Depends on btu_pkg, btu_div (time split) and btu_ram (reply word store).
//
//  channel   handshake                   payload
//  -------   -------------------------   ---------------------------------------------
//  item in   start, busy (accept: !busy) cmd, bus_id, reader_id, command_word, elapsed_ms
//  result    done (one-cycle strobe)     ok, available, data_word
//  config    psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// Non-matching transmits, polls, echo receives and empty receives leave the block free in
// the next cycle; the result appears on the cycle after the transfer. A receive of a reply
// word keeps the block busy in the read state while the reply memory is read; its result
// passes through the memory's read register, then the result registers. A matching timing
// read command keeps the block busy for four divisions by a constant (two 18-bit digits,
// each a multiply and a subtract step), a packing step and one write per reply word.
// Reset clears the reader counts and echo flags; the reply memory needs no clearing pass.
// The result strobe cannot be stalled by the receiver.
module bus_timing_unit_responder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [btu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  cmd,
    input  logic [5:0]                  bus_id,
    input  logic [2:0]                  reader_id,
    input  logic [31:0]                 command_word,
    input  logic [btu_pkg::MS_W-1:0]    elapsed_ms,
    output logic                        done,
    output logic                        ok,
    output logic                        available,
    output logic [btu_pkg::DATA_W-1:0]  data_word
);
    import btu_pkg::*;

    // Configuration registers.
    logic [4:0]  dev_addr_reg;
    logic [18:0] read_field_reg;
    reg_idx_t    reg_idx;
    logic        cfg_write;

    // Per-reader and per-bus state.
    logic [LEFT_W-1:0] left_reg [NUM_BUSES][NUM_READERS];
    logic              pend_reg [NUM_BUSES][NUM_READERS];
    logic [CMDW_W-1:0] echo_reg [NUM_BUSES];

    // Fill sequencer.
    state_t            state_reg, state_next;
    phase_t            phase_reg;
    logic [BUS_W-1:0]  fill_bus_reg;
    logic [MS_W-1:0]   carry_reg;
    logic [DIV_W-1:0]  ms_rem_reg;
    logic [5:0]        sec_reg;
    logic [5:0]        min_reg;
    logic [4:0]        hr_reg;
    logic [8:0]        days_reg;
    logic [WORD_W-1:0] dyhr_reg, mnsc_reg, msec_reg;
    logic [WIDX_W-1:0] widx_reg;

    // Result registers.
    logic              done_reg;
    logic              ok_reg;
    logic              avail_reg;
    logic [DATA_W-1:0] data_reg;

    // Decode of the offered item.
    cmd_t                op;
    logic                accept;
    logic                bus_hit;
    logic [BUS_W-1:0]    sel_bus;
    logic [READER_W-1:0] sel_rdr;
    logic [LEFT_W-1:0]   sel_left;
    logic                sel_pend;
    logic [CMDW_W-1:0]   cmd_masked;
    logic                match;
    logic                is_fill;
    logic                rx_echo;
    logic                rx_data;
    logic [WIDX_W-1:0]   cursor;

    // Memory and divider connections.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    btu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    btu_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- configuration port
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg   <= DEV_ADDR_RESET;
            read_field_reg <= READ_FIELD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_DEV_ADDR:   dev_addr_reg   <= pwdata[4:0];
                REG_READ_FIELD: read_field_reg <= pwdata[18:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEV_ADDR:   prdata = 32'(dev_addr_reg);
            REG_READ_FIELD: prdata = 32'(read_field_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- item decode
    always_comb
    begin
        op         = cmd_t'(cmd);
        accept     = start && !busy;
        bus_hit    = (bus_id >= 6'(FIRST_BUS)) && (7'(bus_id) < 7'(FIRST_BUS + NUM_BUSES));
        sel_bus    = bus_hit ? BUS_W'(bus_id - 6'(FIRST_BUS)) : '0;
        sel_rdr    = (4'(reader_id) < 4'(NUM_READERS)) ? READER_W'(reader_id) : '0;
        sel_left   = left_reg[sel_bus][sel_rdr];
        sel_pend   = pend_reg[sel_bus][sel_rdr];
        cmd_masked = command_word[CMDW_W-1:0];
        match      = (cmd_masked[23:19] == dev_addr_reg) && (cmd_masked[18:0] == read_field_reg);
        is_fill    = (op == CMD_TX_CMD) && match;
        rx_echo    = (op == CMD_RX_WORD) && sel_pend;
        rx_data    = (op == CMD_RX_WORD) && !sel_pend && (sel_left != '0);
        // The cursor always trails the count: a fill sets both, each read moves both.
        cursor     = WIDX_W'(LEFT_W'(REPLY_WORDS) - sel_left);
        ram_re     = accept && rx_data;
        ram_raddr  = ADDR_W'(int'(sel_bus) * REPLY_WORDS) + ADDR_W'(cursor);
    end

    // ---------------------------------------------------------------- reader state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUSES; b++)
            begin
                for (int r = 0; r < NUM_READERS; r++)
                begin
                    left_reg[b][r] <= '0;
                    pend_reg[b][r] <= 1'b0;
                end
            end
        end
        else if (accept)
        begin
            case (op)
                CMD_TX_CMD:
                begin
                    for (int r = 0; r < NUM_READERS; r++)
                    begin
                        left_reg[sel_bus][r] <= match ? LEFT_W'(REPLY_WORDS) : '0;
                        pend_reg[sel_bus][r] <= (sel_rdr != '0) && (r != 0)
                                                && (READER_W'(r) != sel_rdr);
                    end
                end
                CMD_RX_WORD:
                begin
                    if (sel_pend)
                    begin
                        pend_reg[sel_bus][sel_rdr] <= 1'b0;
                    end
                    else if (sel_left != '0)
                    begin
                        left_reg[sel_bus][sel_rdr] <= sel_left - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == CMD_TX_CMD)
        begin
            echo_reg[sel_bus] <= cmd_masked;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_fill)
                begin
                    state_next = ST_DIV_START;
                end
                else if (accept && rx_data)
                begin
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA:     state_next = ST_IDLE;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (phase_reg == PH_HR) ? ST_PACK : ST_DIV_START;
                end
            end
            ST_PACK:      state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (widx_reg == WIDX_W'(REPLY_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy             = state_reg != ST_IDLE;
        div_req.start    = state_reg == ST_DIV_START;
        div_req.dividend = carry_reg;
        case (phase_reg)
            PH_MS:   div_req.divisor = DIV_MS;
            PH_SEC:  div_req.divisor = DIV_SEC;
            PH_MIN:  div_req.divisor = DIV_MIN;
            default: div_req.divisor = DIV_HR;
        endcase
        ram_we    = state_reg == ST_WRITE;
        ram_waddr = ADDR_W'(int'(fill_bus_reg) * REPLY_WORDS) + ADDR_W'(widx_reg);
        if (widx_reg == WIDX_W'(0))
        begin
            ram_wdata = dyhr_reg;
        end
        else if (widx_reg == WIDX_W'(1))
        begin
            ram_wdata = mnsc_reg;
        end
        else if (widx_reg == WIDX_W'(2))
        begin
            ram_wdata = msec_reg;
        end
        else
        begin
            ram_wdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_MS;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                phase_reg <= PH_MS;
                widx_reg  <= '0;
            end
            else if (state_reg == ST_DIV_WAIT && div_rsp.done)
            begin
                phase_reg <= phase_t'(phase_reg + 2'd1);
            end
            else if (state_reg == ST_WRITE)
            begin
                widx_reg <= widx_reg + 1'b1;
            end
        end
    end

    // Each division hands its quotient on as the next dividend.
    always_ff @(posedge clk)
    begin
        if (accept && is_fill)
        begin
            fill_bus_reg <= sel_bus;
            carry_reg    <= elapsed_ms;
        end
        else if (state_reg == ST_DIV_WAIT && div_rsp.done)
        begin
            carry_reg <= div_rsp.quotient;
            case (phase_reg)
                PH_MS:   ms_rem_reg <= div_rsp.remainder;
                PH_SEC:  sec_reg    <= 6'(div_rsp.remainder);
                PH_MIN:  min_reg    <= 6'(div_rsp.remainder);
                default:
                begin
                    hr_reg   <= 5'(div_rsp.remainder);
                    // A 35-bit count of milliseconds stays below 400 days.
                    days_reg <= 9'(div_rsp.quotient);
                end
            endcase
        end
        if (state_reg == ST_PACK)
        begin
            dyhr_reg <= pack_dyhr(days_reg, hr_reg);
            mnsc_reg <= pack_mnsc(min_reg, sec_reg);
            msec_reg <= pack_msec(ms_rem_reg);
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (accept && !rx_data) || (state_reg == ST_RDATA);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= (op == CMD_TX_CMD) || (op == CMD_TX_WORD);
            avail_reg <= ((op == CMD_POLL) || (op == CMD_RX_WORD))
                         && (sel_pend || sel_left != '0);
            data_reg  <= rx_echo ? (DATA_W'(echo_reg[sel_bus]) | SYNC_WORD) : '0;
        end
        else if (state_reg == ST_RDATA)
        begin
            ok_reg    <= 1'b0;
            avail_reg <= 1'b1;
            data_reg  <= DATA_W'(ram_rdata);
        end
    end

    assign done      = done_reg;
    assign ok        = ok_reg;
    assign available = avail_reg;
    assign data_word = data_reg;

    a_accept_answered : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("transfer produced neither a result nor a busy cycle");

    a_rdata_result : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDATA) |=> (done && available))
        else $error("reply word read did not produce an available result");

    a_left_bound : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> sel_left <= LEFT_W'(REPLY_WORDS))
        else $error("reader count exceeds the reply length");

    a_div_done_state : assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("division finished outside the wait state");

endmodule
